// ===== hw/rtl/ps2mt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mt_pkg - shared definitions for the PS/2 mouse packet tracker
// Header bit positions, reset limits, register indexes and framing states.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    // Default cursor coordinate width
    localparam int COORD_BITS_DEFAULT = 12;

    // Reset values of the limit registers (masked to the coordinate width)
    localparam int LIMIT_X_RESET = 1023;
    localparam int LIMIT_Y_RESET = 767;

    // Header byte bit positions
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int BTN_BITS      = 3;

    // Raw delta byte width; the sign-extended delta is one bit wider
    localparam int DELTA_BITS = 8;

    // Register indexes on the configuration port
    localparam logic REG_LIMIT_X = 1'b0;
    localparam logic REG_LIMIT_Y = 1'b1;

    // Position within a three-byte packet
    typedef enum logic [2:0] {
        SLOT_HDR = 3'b001,
        SLOT_X   = 3'b010,
        SLOT_Y   = 3'b100
    } slot_t;

endpackage

// ===== hw/rtl/ps2_mouse_packet_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker - PS/2 three-byte mouse packet decoder
// Frames auxiliary bytes into packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_stall, rx_byte, from_aux) carries bytes
//   read from the controller; bytes with from_aux low are discarded. A header
//   byte without bit 3 set is dropped to regain packet framing.
//   Position channel (pos_valid/pos_stall, cursor_x, cursor_y, button_bits)
//   carries one transaction per completed three-byte packet.
//   A byte taken is held in the input register and processed from there;
//   the resulting position is presented from the output register.
//   Throughput: one byte per cycle unless a position transaction stalls, set
//   by the single input register feeding the combinational framing and axis logic.
//   A stalled position transaction holds in the output register; a byte
//   already in the input register then holds as well and byte_stall rises,
//   so at most one byte waits behind a stalled transaction.
//   Reset: framing returns to the header slot, limits go to 1023 and 767
//   (masked to COORD_BITS) and the cursor to the centre of each range.
//   APB: limit_x at 0x0, limit_y at 0x4; a write recentres that axis to
//   (limit+1)/2. Write only while no transaction is in flight.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Byte channel
    input  logic                             byte_valid,
    output logic                             byte_stall,
    input  logic [7:0]                       rx_byte,
    input  logic                             from_aux,
    // Position channel
    output logic                             pos_valid,
    input  logic                             pos_stall,
    output logic [COORD_BITS-1:0]            cursor_x,
    output logic [COORD_BITS-1:0]            cursor_y,
    output logic [ps2mt_pkg::BTN_BITS-1:0]   button_bits
);

    // Reset limits masked to the coordinate width, and their centres
    localparam int LimXRst = ps2mt_pkg::LIMIT_X_RESET % (2 ** COORD_BITS);
    localparam int LimYRst = ps2mt_pkg::LIMIT_Y_RESET % (2 ** COORD_BITS);
    localparam logic [COORD_BITS-1:0] LimXInit = COORD_BITS'(LimXRst);
    localparam logic [COORD_BITS-1:0] LimYInit = COORD_BITS'(LimYRst);
    localparam logic [COORD_BITS-1:0] CurXInit = COORD_BITS'((LimXRst + 1) / 2);
    localparam logic [COORD_BITS-1:0] CurYInit = COORD_BITS'((LimYRst + 1) / 2);

    // Input register
    logic                   s1_valid_reg, s1_valid_next;
    logic [7:0]             s1_byte_reg;
    logic                   s1_aux_reg;

    // Framing state
    ps2mt_pkg::slot_t       slot_reg, slot_next;
    logic                   xsign_reg, xsign_next;
    logic                   ysign_reg, ysign_next;
    logic [ps2mt_pkg::BTN_BITS-1:0] btn_reg, btn_next;
    logic [7:0]             xbyte_reg, xbyte_next;

    // Position and limits
    logic [COORD_BITS-1:0]  limit_x_reg, limit_x_next;
    logic [COORD_BITS-1:0]  limit_y_reg, limit_y_next;
    logic [COORD_BITS-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]  cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]  step_x, step_y;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]  out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]  out_y_reg, out_y_next;
    logic [ps2mt_pkg::BTN_BITS-1:0] out_btn_reg, out_btn_next;

    logic                   byte_accept;
    logic                   advance;
    logic                   pkt_done;
    logic                   cfg_write;
    logic                   cfg_index;
    logic [COORD_BITS:0]    wr_plus_one;

    // ------------------------------------------------------------------
    // Handshakes: the processing stage advances when the output register
    // is free or being drained this cycle.
    // ------------------------------------------------------------------
    assign advance     = s1_valid_reg && (!out_valid_reg || !pos_stall);
    assign byte_stall  = s1_valid_reg && !advance;
    assign byte_accept = byte_valid && !byte_stall;

    assign cfg_write   = psel && penable && pwrite;
    assign cfg_index   = paddr[2];
    assign pready      = 1'b1;
    assign wr_plus_one = {1'b0, pwdata[COORD_BITS-1:0]} + (COORD_BITS+1)'(1);

    // Axis updates, one instance per axis, applied at the third byte of every packet
    ps2mt_axis_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step_x (
        .cur        (cur_x_reg),
        .limit      (limit_x_reg),
        .delta_byte (xbyte_reg),
        .delta_sign (xsign_reg),
        .subtract   (1'b0),
        .cur_next   (step_x)
    );

    ps2mt_axis_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step_y (
        .cur        (cur_y_reg),
        .limit      (limit_y_reg),
        .delta_byte (s1_byte_reg),
        .delta_sign (ysign_reg),
        .subtract   (1'b1),
        .cur_next   (step_y)
    );

    // ------------------------------------------------------------------
    // Framing, position update, limit writes and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next  = byte_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        slot_next      = slot_reg;
        xsign_next     = xsign_reg;
        ysign_next     = ysign_reg;
        btn_next       = btn_reg;
        xbyte_next     = xbyte_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        limit_x_next   = limit_x_reg;
        limit_y_next   = limit_y_reg;
        pkt_done       = 1'b0;

        if (advance && s1_aux_reg)
        begin
            case (slot_reg)
                ps2mt_pkg::SLOT_HDR:
                begin
                    // Drop a header without the sync bit to regain framing
                    if (s1_byte_reg[ps2mt_pkg::HDR_SYNC_BIT])
                    begin
                        xsign_next = s1_byte_reg[ps2mt_pkg::HDR_XSIGN_BIT];
                        ysign_next = s1_byte_reg[ps2mt_pkg::HDR_YSIGN_BIT];
                        btn_next   = s1_byte_reg[ps2mt_pkg::BTN_BITS-1:0];
                        slot_next  = ps2mt_pkg::SLOT_X;
                    end
                end
                ps2mt_pkg::SLOT_X:
                begin
                    xbyte_next = s1_byte_reg;
                    slot_next  = ps2mt_pkg::SLOT_Y;
                end
                default:
                begin
                    cur_x_next = step_x;
                    cur_y_next = step_y;
                    pkt_done   = 1'b1;
                    slot_next  = ps2mt_pkg::SLOT_HDR;
                end
            endcase
        end

        // Limit writes must arrive only while idle (not enforced here); recentre the written axis
        if (cfg_write)
        begin
            case (cfg_index)
                ps2mt_pkg::REG_LIMIT_X:
                begin
                    limit_x_next = pwdata[COORD_BITS-1:0];
                    cur_x_next   = wr_plus_one[COORD_BITS:1];
                end
                ps2mt_pkg::REG_LIMIT_Y:
                begin
                    limit_y_next = pwdata[COORD_BITS-1:0];
                    cur_y_next   = wr_plus_one[COORD_BITS:1];
                end
                default:
                begin
                    limit_x_next = limit_x_reg;
                end
            endcase
        end

        // Hold a stalled transaction; load a fresh one when a packet completes
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_btn_next = out_btn_reg;
        if (pkt_done)
        begin
            out_valid_next = 1'b1;
            out_x_next     = step_x;
            out_y_next     = step_y;
            out_btn_next   = btn_reg;
        end
        else if (out_valid_reg && !pos_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            slot_reg      <= ps2mt_pkg::SLOT_HDR;
            xsign_reg     <= 1'b0;
            ysign_reg     <= 1'b0;
            btn_reg       <= '0;
            xbyte_reg     <= '0;
            limit_x_reg   <= LimXInit;
            limit_y_reg   <= LimYInit;
            cur_x_reg     <= CurXInit;
            cur_y_reg     <= CurYInit;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            slot_reg      <= slot_next;
            xsign_reg     <= xsign_next;
            ysign_reg     <= ysign_next;
            btn_reg       <= btn_next;
            xbyte_reg     <= xbyte_next;
            limit_x_reg   <= limit_x_next;
            limit_y_reg   <= limit_y_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_aux_reg  <= from_aux;
        end
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_btn_reg <= out_btn_next;
    end

    // Register readback
    always_comb
    begin
        case (cfg_index)
            ps2mt_pkg::REG_LIMIT_X: prdata = 32'(limit_x_reg);
            ps2mt_pkg::REG_LIMIT_Y: prdata = 32'(limit_y_reg);
            default:                prdata = '0;
        endcase
    end

    assign pos_valid   = out_valid_reg;
    assign cursor_x    = out_x_reg;
    assign cursor_y    = out_y_reg;
    assign button_bits = out_btn_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The tracked position never leaves its range
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_x_reg <= limit_x_reg) && (cur_y_reg <= limit_y_reg))
        else $error("cursor position beyond its limit");

    // The input register holds only behind a stalled position transaction
    a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> (out_valid_reg && pos_stall))
        else $error("input register held without an output stall");

    // A third byte completes a packet: result presented, framing back to header
    a_packet_close: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_aux_reg && (slot_reg == ps2mt_pkg::SLOT_Y))
        |=> (out_valid_reg && (slot_reg == ps2mt_pkg::SLOT_HDR)))
        else $error("completed packet did not produce a position");

endmodule

// ===== hw/rtl/ps2mt_axis_step.sv =====
// ----------------------------------------------------------------------------
// ps2mt_axis_step - one cursor axis update
// Add or subtract a 9-bit signed delta and clamp the result to 0..limit.
// ----------------------------------------------------------------------------
module ps2mt_axis_step #(
    parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
) (
    input  logic [COORD_BITS-1:0]           cur,
    input  logic [COORD_BITS-1:0]           limit,
    input  logic [ps2mt_pkg::DELTA_BITS-1:0] delta_byte,
    input  logic                            delta_sign,
    input  logic                            subtract,
    output logic [COORD_BITS-1:0]           cur_next
);

    localparam int SumW = COORD_BITS + 2;

    logic signed [ps2mt_pkg::DELTA_BITS:0] delta;
    logic signed [SumW-1:0]                cur_ext;
    logic signed [SumW-1:0]                delta_ext;
    logic signed [SumW-1:0]                sum;

    always_comb
    begin
        delta     = {delta_sign, delta_byte};
        cur_ext   = SumW'({2'b00, cur});
        delta_ext = SumW'(delta);
        sum       = subtract ? (cur_ext - delta_ext) : (cur_ext + delta_ext);

        // Clamp below at zero, above at the limit
        if (sum[SumW-1])
        begin
            cur_next = '0;
        end
        else if (sum[SumW-2:0] > {1'b0, limit})
        begin
            cur_next = limit;
        end
        else
        begin
            cur_next = sum[COORD_BITS-1:0];
        end
    end

endmodule

// ===== tb/sv/tb_ps2_mouse_packet_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker - self-checking bench for the PS/2 packet tracker
// Drives auxiliary and foreign bytes through the byte channel, tracks packet
// framing and the clamped cursor in a local model, and compares every
// position transaction field by field. Limits are rewritten over APB between
// phases, and the channels idle at random in two mixes plus a third with no idling.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker;

    import ps2mt_pkg::*;

    localparam int CB             = COORD_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
    localparam int LATENCY_PAUSE  = 4;     // byte register plus output register
    localparam int SUBPHASE_BYTES = 165;   // framed bytes per limit setting

    typedef struct packed {
        logic [CB-1:0]       x;
        logic [CB-1:0]       y;
        logic [BTN_BITS-1:0] btn;
    } position_t;

    // DUT ports
    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                byte_valid;
    logic                byte_stall;
    logic [7:0]          rx_byte;
    logic                from_aux;
    logic                pos_valid;
    logic                pos_stall;
    logic [CB-1:0]       cursor_x;
    logic [CB-1:0]       cursor_y;
    logic [BTN_BITS-1:0] button_bits;

    // Local tracker: framing state, cursor and limits
    slot_t               frame_slot;
    logic [7:0]          held_header;
    logic [7:0]          held_xdelta;
    logic [CB-1:0]       track_x;
    logic [CB-1:0]       track_y;
    logic [CB-1:0]       limit_x_q;
    logic [CB-1:0]       limit_y_q;

    position_t           expected_positions[$];

    // Run controls and tallies
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  noise_pct;
    int                  error_count;
    int                  bytes_sent;
    int                  framed_bytes;
    int                  positions_checked;
    int                  limit_writes;

    ps2_mouse_packet_tracker #(
        .COORD_BITS (CB)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .rx_byte     (rx_byte),
        .from_aux    (from_aux),
        .pos_valid   (pos_valid),
        .pos_stall   (pos_stall),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .button_bits (button_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------
    function automatic logic [CB-1:0] centre_of(input logic [CB-1:0] lim);
        return CB'((int'(lim) + 1) / 2);
    endfunction

    // Widen a raw delta byte with the sign bit carried in the header
    function automatic int widen_delta(input logic [7:0] raw, input logic neg);
        return neg ? int'(raw) - 256 : int'(raw);
    endfunction

    function automatic logic [CB-1:0] clamp_axis(input int v, input logic [CB-1:0] lim);
        if (v < 0)
            return '0;
        if (v > int'(lim))
            return lim;
        return CB'(v);
    endfunction

    function automatic logic [2:0] reg_addr(input logic idx);
        return {idx, 2'b00};
    endfunction

    // Advance the local tracker by one accepted byte; queue a position when a
    // packet completes.
    task automatic track_packet_byte(input logic [7:0] b, input logic aux);
        position_t pos;
        int        dx;
        int        dy;
        // Foreign bytes never touch the framing
        if (!aux)
            return;
        case (frame_slot)
            SLOT_HDR:
            begin
                // Drop a header without the sync bit to regain framing
                if (!b[HDR_SYNC_BIT])
                    return;
                held_header = b;
                frame_slot  = SLOT_X;
            end
            SLOT_X:
            begin
                held_xdelta = b;
                frame_slot  = SLOT_Y;
            end
            default:
            begin
                // Third byte completes the packet: add X, subtract Y, clamp
                frame_slot = SLOT_HDR;
                dx = widen_delta(held_xdelta, held_header[HDR_XSIGN_BIT]);
                dy = widen_delta(b, held_header[HDR_YSIGN_BIT]);
                track_x = clamp_axis(int'(track_x) + dx, limit_x_q);
                track_y = clamp_axis(int'(track_y) - dy, limit_y_q);
                pos.x   = track_x;
                pos.y   = track_y;
                pos.btn = held_header[BTN_BITS-1:0];
                expected_positions.push_back(pos);
            end
        endcase
        framed_bytes++;
    endtask

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Byte channel driver: change at the falling edge, accept at the rising
    // edge. Valid is left high after a transaction so that back-to-back bytes
    // never see it dropped and raised in one step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic aux);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        rx_byte    = b;
        from_aux   = aux;
        byte_valid = 1'b1;
        do
            @(posedge clk);
        while (byte_stall);
        bytes_sent++;
        track_packet_byte(b, aux);
    endtask

    // Auxiliary byte, optionally preceded by a foreign byte
    task automatic send_aux(input logic [7:0] b);
        if ($urandom_range(99) < noise_pct)
            send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(b, 1'b1);
    endtask

    // Build a well-formed packet; overflow bits 6 and 7 are random
    task automatic send_packet(input logic [2:0] btn, input int dx, input int dy);
        logic [7:0] hdr;
        hdr = 8'($urandom_range(255));
        hdr[HDR_SYNC_BIT]  = 1'b1;
        hdr[HDR_XSIGN_BIT] = (dx < 0);
        hdr[HDR_YSIGN_BIT] = (dy < 0);
        hdr[2:0]           = btn;
        send_aux(hdr);
        send_aux(dx[7:0]);
        send_aux(dy[7:0]);
    endtask

    // Drop valid, wait for every queued position, then let the byte that may
    // still sit in the input register settle.
    task automatic wait_quiet();
        @(negedge clk);
        byte_valid = 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // APB access: setup phase at a falling edge, access phase with penable high,
    // completion at the rising edge with pready high.
    // ------------------------------------------------------------------------
    task automatic read_limit(input logic idx);
        logic [31:0] want;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = reg_addr(idx);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        want = 32'((idx == REG_LIMIT_X) ? limit_x_q : limit_y_q);
        if (prdata !== want)
            report_error($sformatf("limit read idx %0d: got %0d want %0d", idx, prdata, want));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_limit(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = reg_addr(idx);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Bits above the coordinate width are discarded; the axis recentres
        if (idx == REG_LIMIT_X)
        begin
            limit_x_q = value[CB-1:0];
            track_x   = centre_of(limit_x_q);
        end
        else
        begin
            limit_y_q = value[CB-1:0];
            track_y   = centre_of(limit_y_q);
        end
        limit_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        read_limit(idx);
    endtask

    // Random upper bits on top of the wanted limit
    function automatic logic [31:0] dirty_word(input int val);
        logic [31:0] w;
        w = $urandom;
        w[CB-1:0] = CB'(val);
        return w;
    endfunction

    // Half small moves of -20..20, half full-range moves of -256..255
    function automatic int pick_delta();
        if ($urandom_range(1) == 0)
            return int'($urandom_range(40)) - 20;
        return int'($urandom_range(511)) - 256;
    endfunction

    // ------------------------------------------------------------------------
    // Position channel: sample at the rising edge, re-roll the stall at the
    // falling edge.
    // ------------------------------------------------------------------------
    initial
    begin
        position_t want;
        forever
        begin
            @(posedge clk);
            if (pos_valid && !pos_stall)
            begin
                if (expected_positions.size() == 0)
                    report_error($sformatf("position (%0d,%0d) btn %0d with none pending",
                                           cursor_x, cursor_y, button_bits));
                else
                begin
                    want = expected_positions.pop_front();
                    positions_checked++;
                    if (cursor_x !== want.x)
                        report_error($sformatf("cursor_x got %0d want %0d", cursor_x, want.x));
                    if (cursor_y !== want.y)
                        report_error($sformatf("cursor_y got %0d want %0d", cursor_y, want.y));
                    if (button_bits !== want.btn)
                        report_error($sformatf("button_bits got %0d want %0d",
                                               button_bits, want.btn));
                end
            end
            @(negedge clk);
            pos_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run after a long stretch with no transaction anywhere
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (pos_valid && !pos_stall) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Limits come up at their defaults and a still packet reports the centre
    task automatic test_reset_state();
        read_limit(REG_LIMIT_X);
        read_limit(REG_LIMIT_Y);
        send_packet(3'b000, 0, 0);
    endtask

    // Foreign bytes are skipped at the header slot and inside a packet
    task automatic test_foreign_bytes();
        send_byte(8'h08, 1'b0);
        send_byte(8'h0F, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Headers without the sync bit are dropped, then full-range deltas
    task automatic test_header_resync();
        send_byte(8'h00, 1'b1);
        send_byte(8'hF7, 1'b1);
        send_packet(3'b010, -256, -256);
        send_packet(3'b101, -1, 255);
    endtask

    // Rewrite a limit between the X delta and the Y delta of one packet
    task automatic test_write_mid_packet();
        send_byte(8'h19, 1'b1);
        send_byte(8'hF0, 1'b1);
        wait_quiet();
        write_limit(REG_LIMIT_X, 32'd200);
        send_byte(8'h05, 1'b1);
    endtask

    // Zero limits pin both axes; full limits with dirty upper bits
    task automatic test_limit_extremes();
        wait_quiet();
        write_limit(REG_LIMIT_X, 32'd0);
        write_limit(REG_LIMIT_Y, 32'hFFFF_0000);
        send_packet(3'b011, 255, -256);
        wait_quiet();
        write_limit(REG_LIMIT_X, 32'hFFFF_FFFF);
        write_limit(REG_LIMIT_Y, 32'h0000_1FFF);
        send_packet(3'b110, 200, -200);
    endtask

    // Mostly well-formed packets with random content, plus foreign bytes,
    // unsynced headers and stray bytes that break the framing
    task automatic test_random_traffic();
        int x_settings[6] = '{15, 4095, 0, 1023, -1, 2047};
        int y_settings[6] = '{9, 4095, 300, 767, -1, 0};
        int target;
        int pick;
        for (int s = 0; s < 6; s++)
        begin
            // Two limit settings per idle mix
            case (s / 2)
                0:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 62;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 16;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            wait_quiet();
            write_limit(REG_LIMIT_X,
                        dirty_word(x_settings[s] < 0 ? $urandom_range(4095) : x_settings[s]));
            write_limit(REG_LIMIT_Y,
                        dirty_word(y_settings[s] < 0 ? $urandom_range(4095) : y_settings[s]));
            noise_pct = (s == 5) ? 0 : 8;
            target    = framed_bytes + SUBPHASE_BYTES;
            while (framed_bytes < target)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    send_packet(3'($urandom_range(7)), pick_delta(), pick_delta());
                else if (pick < 88)
                    send_byte(8'($urandom_range(255)), 1'b0);
                else if (pick < 94)
                    send_byte(8'($urandom_range(255)) & ~8'h08, 1'b1);
                else if (pick < 99)
                    send_byte(8'($urandom_range(255)), 1'b1);
                else
                    wait_quiet();  // hold the sender until the output drains
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        byte_valid = 1'b0;
        rx_byte    = '0;
        from_aux   = 1'b0;
        pos_stall  = 1'b0;

        frame_slot   = SLOT_HDR;
        held_header  = '0;
        held_xdelta  = '0;
        limit_x_q    = CB'(LIMIT_X_RESET);
        limit_y_q    = CB'(LIMIT_Y_RESET);
        track_x      = centre_of(limit_x_q);
        track_y      = centre_of(limit_y_q);

        send_idle_pct     = 16;
        recv_stall_pct    = 62;
        noise_pct         = 0;
        error_count       = 0;
        bytes_sent        = 0;
        framed_bytes      = 0;
        positions_checked = 0;
        limit_writes      = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_foreign_bytes();
        test_header_resync();
        test_write_mid_packet();
        test_limit_extremes();
        test_random_traffic();

        // Drain, then give the pipeline time to show anything stray
        wait_quiet();
        repeat (2 * LATENCY_PAUSE) @(posedge clk);
        if (expected_positions.size() != 0)
            report_error($sformatf("%0d positions never arrived", expected_positions.size()));

        $display("Sent %0d bytes (%0d framed), checked %0d positions, %0d limit writes",
                 bytes_sent, framed_bytes, positions_checked, limit_writes);
        $display("Covered resync, foreign bytes, mid-packet writes, limits 0..4095, three idle mixes");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
